// ----- hdl/psrl_pkg.sv -----
`timescale 1ns / 1ps
// psrl_pkg: shared types and constants of the source-text run lexer
// lexer modes, run kind codes, character codes and the queue entry width
// no dependencies
package psrl_pkg;

   // lexer mode of the front end
   typedef enum logic [2:0] {
      MODE_CODE,
      MODE_COMMENT,
      MODE_OPEN1,
      MODE_OPEN2,
      MODE_BODY
   } mode_type;

   // run kind codes as they leave the block
   localparam logic [1:0] KIND_CODE    = 2'd0;
   localparam logic [1:0] KIND_STRING  = 2'd1;
   localparam logic [1:0] KIND_COMMENT = 2'd2;
   localparam logic [1:0] KIND_SUBST   = 2'd3;

   // characters the lexer reacts to
   localparam logic [7:0] CHAR_SQUOTE  = 8'h27;
   localparam logic [7:0] CHAR_DQUOTE  = 8'h22;
   localparam logic [7:0] CHAR_HASH    = 8'h23;
   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_LPAREN  = 8'h28;
   localparam logic [7:0] CHAR_RPAREN  = 8'h29;
   localparam logic [7:0] CHAR_BSLASH  = 8'h5C;
   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] CHAR_LF      = 8'h0A;

   // fixed field widths of the ports
   localparam int START_BITS  = 24;
   localparam int LENGTH_BITS = 25;

   // queue entry: a two-run flag and two runs of kind, start and end (exclusive)
   function automatic int entry_bits(input int pos_bits);
      return 1 + 2 * (2 + pos_bits + pos_bits + 1);
   endfunction

endpackage

// ----- hdl/psrl_front.sv -----
`timescale 1ns / 1ps
// psrl_front: accepts bytes, tracks the lexer mode and position, and
// produces up to two finished runs per byte for the queue
// depends on psrl_pkg
module psrl_front #(
   parameter int POS_BITS = 24
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   input  logic [7:0]                                req_tdata,  // text_byte
   input  logic                                      req_tlast,  // is_last
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic [psrl_pkg::START_BITS-1:0]           csr_data,   // start_offset
   input  logic                                      q_full,
   output logic                                      q_push,
   output logic [psrl_pkg::entry_bits(POS_BITS)-1:0] q_data
);
   import psrl_pkg::*;

   // same layout as in the back end
   typedef struct packed {
      logic [1:0]          kind;
      logic [POS_BITS-1:0] start;
      logic [POS_BITS:0]   stop;
   } run_type;

   typedef struct packed {
      logic    two;
      run_type first;
      run_type second;
   } entry_type;

   localparam logic [POS_BITS-1:0] POS_MAX      = '1;
   localparam logic [32:0]         POS_MAX_WIDE = 33'((64'd1 << POS_BITS) - 64'd1);

   // state registers
   mode_type            mode_ff,   mode_in;
   logic [7:0]          quote_ff,  quote_in;
   logic                triple_ff, triple_in;
   logic                pct_ff,    pct_in;
   logic                lookup_ff, lookup_in;
   logic                esc_ff,    esc_in;
   logic [1:0]          close_ff,  close_in;
   logic [POS_BITS-1:0] pos_ff;
   logic [POS_BITS:0]   ors_ff;
   logic                started_ff;
   logic [POS_BITS-1:0] offset_ff;

   // byte decode and run construction
   logic                accept;
   logic [7:0]          c;
   logic                is_quote;
   logic                is_eol;
   logic                do_code;
   logic                do_body;
   logic                do_close;
   logic                fire;
   logic [1:0]          fire_kind;
   logic                fire_inc;
   logic [POS_BITS:0]   p_ext;
   logic [POS_BITS:0]   p_inc;
   logic                p_ge;
   logic                p_gt;
   logic [POS_BITS:0]   ors_a;
   logic                a_ok;
   logic                b_ok;
   logic [1:0]          kind_b;
   run_type             run_a;
   run_type             run_b;
   entry_type           entry;
   logic [32:0]         csr_wide;
   logic [POS_BITS-1:0] offset_capped;

   function automatic logic is_letter(input logic [7:0] ch);
      return (ch >= 8'h61 && ch <= 8'h7A) || (ch >= 8'h41 && ch <= 8'h5A);
   endfunction

   assign req_tready = !q_full;
   assign csr_ready  = 1'b1;
   assign accept     = req_tvalid && req_tready;
   assign c          = req_tdata;
   assign is_quote   = (c == quote_ff);
   assign is_eol     = (c == CHAR_CR) || (c == CHAR_LF);

   // position compare shared by both runs
   assign p_ext = {1'b0, pos_ff};
   assign p_inc = p_ext + (POS_BITS + 1)'(1);
   assign p_ge  = (p_ext >= ors_ff);
   assign p_gt  = p_ge && (p_ext != ors_ff);

   // start offset cut to the position range
   assign csr_wide      = 33'(csr_data);
   assign offset_capped = (csr_wide > POS_MAX_WIDE) ? POS_MAX : csr_wide[POS_BITS-1:0];

   // next mode and the run closed by this byte
   always_comb begin
      mode_in   = mode_ff;
      quote_in  = quote_ff;
      triple_in = triple_ff;
      pct_in    = pct_ff;
      lookup_in = lookup_ff;
      esc_in    = esc_ff;
      close_in  = close_ff;
      fire      = 1'b0;
      fire_kind = KIND_CODE;
      fire_inc  = 1'b0;
      do_code   = 1'b0;
      do_body   = 1'b0;
      do_close  = 1'b0;

      case (mode_ff)
         MODE_COMMENT: begin
            if (is_eol) begin
               fire      = 1'b1;
               fire_kind = KIND_COMMENT;
               fire_inc  = 1'b1;
               mode_in   = MODE_CODE;
            end
         end
         MODE_OPEN1: begin
            if (is_quote) begin
               mode_in = MODE_OPEN2;
            end else begin
               mode_in = MODE_BODY;
               do_body = 1'b1;
            end
         end
         MODE_OPEN2: begin
            if (is_quote) begin
               triple_in = 1'b1;
               mode_in   = MODE_BODY;
            end else begin
               // empty string, the byte is looked at again as code
               fire      = 1'b1;
               fire_kind = KIND_STRING;
               fire_inc  = 1'b0;
               mode_in   = MODE_CODE;
               do_code   = 1'b1;
            end
         end
         MODE_BODY: begin
            do_body = 1'b1;
         end
         default: begin
            mode_in = MODE_CODE;
            do_code = 1'b1;
         end
      endcase

      // string body byte
      if (do_body) begin
         if (esc_ff) begin
            esc_in = 1'b0;
         end else if (close_ff != 2'd0 && is_quote) begin
            if (close_ff == 2'd2) begin
               do_close = 1'b1;
            end else begin
               close_in = close_ff + 2'd1;
            end
         end else begin
            // broken triple close falls through as a normal byte
            close_in = 2'd0;
            if (pct_ff) begin
               if (is_letter(c)) begin
                  fire      = 1'b1;
                  fire_kind = KIND_SUBST;
                  fire_inc  = 1'b1;
               end else if (c == CHAR_LPAREN) begin
                  lookup_in = 1'b1;
               end
            end
            pct_in = 1'b0;
            if (is_quote) begin
               if (triple_ff) begin
                  close_in = 2'd1;
               end else begin
                  do_close = 1'b1;
               end
            end else if (c == CHAR_BSLASH) begin
               esc_in = 1'b1;
            end else if (is_eol) begin
               if (!triple_ff) begin
                  do_close = 1'b1;
               end
            end else if (c == CHAR_PERCENT) begin
               fire      = 1'b1;
               fire_kind = KIND_STRING;
               fire_inc  = 1'b0;
               pct_in    = 1'b1;
            end else if (c == CHAR_RPAREN && lookup_ff) begin
               fire      = 1'b1;
               fire_kind = KIND_SUBST;
               fire_inc  = 1'b1;
               lookup_in = 1'b0;
            end
         end
      end

      // string ends at this byte
      if (do_close) begin
         fire      = 1'b1;
         fire_kind = lookup_ff ? KIND_SUBST : KIND_STRING;
         fire_inc  = 1'b1;
         triple_in = 1'b0;
         pct_in    = 1'b0;
         lookup_in = 1'b0;
         esc_in    = 1'b0;
         close_in  = 2'd0;
         mode_in   = MODE_CODE;
      end

      // code byte: quote opens a string, hash a comment
      if (do_code) begin
         if (c == CHAR_SQUOTE || c == CHAR_DQUOTE) begin
            if (!fire) begin
               fire      = 1'b1;
               fire_kind = KIND_CODE;
               fire_inc  = 1'b0;
            end
            quote_in  = c;
            triple_in = 1'b0;
            pct_in    = 1'b0;
            lookup_in = 1'b0;
            esc_in    = 1'b0;
            close_in  = 2'd0;
            mode_in   = MODE_OPEN1;
         end else if (c == CHAR_HASH) begin
            if (!fire) begin
               fire      = 1'b1;
               fire_kind = KIND_CODE;
               fire_inc  = 1'b0;
            end
            mode_in = MODE_COMMENT;
         end
      end
   end

   // run start after the mode run, and the end-of-text run
   always_comb begin
      ors_a = ors_ff;
      if (fire) begin
         ors_a = fire_inc ? p_inc : p_ext;
      end
      a_ok = fire && (fire_inc ? p_ge : p_gt);
      b_ok = req_tlast && (fire ? !fire_inc : p_ge);
      case (mode_in)
         MODE_CODE:    kind_b = KIND_CODE;
         MODE_COMMENT: kind_b = KIND_COMMENT;
         default:      kind_b = lookup_in ? KIND_SUBST : KIND_STRING;
      endcase
   end

   // queue entry, the first valid run always in front
   always_comb begin
      run_a.kind   = fire_kind;
      run_a.start  = ors_ff[POS_BITS-1:0];
      run_a.stop   = fire_inc ? p_inc : p_ext;
      run_b.kind   = kind_b;
      run_b.start  = ors_a[POS_BITS-1:0];
      run_b.stop   = p_inc;
      entry.two    = a_ok && b_ok;
      entry.first  = a_ok ? run_a : run_b;
      entry.second = run_b;
   end

   assign q_push = accept && (a_ok || b_ok);
   assign q_data = entry;

   // lexer state register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_CODE;
         quote_ff   <= 8'h00;
         triple_ff  <= 1'b0;
         pct_ff     <= 1'b0;
         lookup_ff  <= 1'b0;
         esc_ff     <= 1'b0;
         close_ff   <= 2'd0;
         pos_ff     <= '0;
         ors_ff     <= '0;
         started_ff <= 1'b0;
         offset_ff  <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            offset_ff <= offset_capped;
         end
         if (accept) begin
            if (req_tlast) begin
               // text done, back to the start of a new one
               mode_ff    <= MODE_CODE;
               quote_ff   <= 8'h00;
               triple_ff  <= 1'b0;
               pct_ff     <= 1'b0;
               lookup_ff  <= 1'b0;
               esc_ff     <= 1'b0;
               close_ff   <= 2'd0;
               pos_ff     <= offset_ff;
               ors_ff     <= {1'b0, offset_ff};
               started_ff <= 1'b0;
            end else begin
               mode_ff    <= mode_in;
               quote_ff   <= quote_in;
               triple_ff  <= triple_in;
               pct_ff     <= pct_in;
               lookup_ff  <= lookup_in;
               esc_ff     <= esc_in;
               close_ff   <= close_in;
               pos_ff     <= (pos_ff == POS_MAX) ? POS_MAX : pos_ff + 1'b1;
               ors_ff     <= ors_a;
               started_ff <= 1'b1;
            end
         end else if (csr_valid && csr_ready && !started_ff) begin
            // offset moves the position at once before the first byte
            pos_ff <= offset_capped;
            ors_ff <= {1'b0, offset_capped};
         end
      end
   end

endmodule

// ----- hdl/psrl_queue.sv -----
`timescale 1ns / 1ps
// psrl_queue: short first-in first-out queue of run entries between the
// front and back ends of the lexer
// no package dependencies
module psrl_queue #(
   parameter int WIDTH = 103,
   parameter int DEPTH = 4   // two or more
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output logic [WIDTH-1:0] head_data
);
   localparam int PTR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    slot_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff,  count_in;

   assign full       = (count_ff == CNT_BITS'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = slot_ff[rd_ptr_ff];

   // pointer and fill level update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- hdl/psrl_back.sv -----
`timescale 1ns / 1ps
// psrl_back: takes run entries from the queue and hands them out one run
// per item through the output register, with length and last-run mark
// depends on psrl_pkg
module psrl_back #(
   parameter int POS_BITS = 24
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      head_valid,
   input  logic [psrl_pkg::entry_bits(POS_BITS)-1:0] head_data,
   output logic                                      pop,
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   output logic [55:0]                               rsp_tdata,  // run_start, run_length
   output logic                                      rsp_tlast,  // final_res
   output logic [1:0]                                rsp_tuser   // run_kind
);
   import psrl_pkg::*;

   // same layout as in the front end
   typedef struct packed {
      logic [1:0]          kind;
      logic [POS_BITS-1:0] start;
      logic [POS_BITS:0]   stop;
   } run_type;

   typedef struct packed {
      logic    two;
      run_type first;
      run_type second;
   } entry_type;

   entry_type              head;
   run_type                cur;
   logic                   load;
   logic                   is_final;
   logic [POS_BITS:0]      diff;
   logic [32:0]            start_wide;
   logic [32:0]            len_wide;
   logic                   sub_ff,   sub_in;
   logic                   valid_ff, valid_in;
   logic [1:0]             kind_ff;
   logic [START_BITS-1:0]  start_ff;
   logic [LENGTH_BITS-1:0] len_ff;
   logic                   last_ff;

   assign head = head_data;

   // pick the run due next and work out its length
   always_comb begin
      cur        = sub_ff ? head.second : head.first;
      is_final   = !head.two || sub_ff;
      load       = head_valid && (!valid_ff || rsp_tready);
      diff       = cur.stop - {1'b0, cur.start};
      start_wide = 33'(cur.start);
      len_wide   = 33'(diff);
      pop        = load && is_final;
      sub_in     = load ? !is_final : sub_ff;
      valid_in   = load ? 1'b1 : (valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         sub_ff   <= sub_in;
         valid_ff <= valid_in;
      end
   end

   // output payload register
   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff  <= cur.kind;
         start_ff <= start_wide[START_BITS-1:0];
         len_ff   <= len_wide[LENGTH_BITS-1:0];
         last_ff  <= is_final;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {7'b0, len_ff, start_ff};
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = kind_ff;

endmodule

// ----- hdl/python_syntax_run_lexer_top.sv -----
`timescale 1ns / 1ps
// Source-text run lexer, top level.
// Bytes of source text enter on the req_ channel, one byte per item, with
// req_tlast on the final byte of a text. Runs of code, string, line comment
// and format substitution leave on the rsp_ channel as kind (rsp_tuser),
// start and length (rsp_tdata); rsp_tlast marks the last run caused by a byte.
// csr_ sets the text position of the first byte; it takes effect at once
// before the first byte of a text, otherwise from the next text.
// A byte is taken every cycle while the four-entry run queue has room; a
// byte that closes no run leaves nothing in the queue. The output register
// sends one run per cycle while rsp_tready is high, so a byte that closes
// two runs holds the output for both of them. A first run passes through
// the queue and then the output register after its byte is accepted.
// When rsp_tready is low the output register holds its run, the queue fills,
// and req_tready drops once it is full.
// Reset (synchronous, active high) empties queue and output, puts the lexer
// in code mode and sets the start position to zero; no clearing pass follows.
// Depends on psrl_pkg, psrl_front, psrl_queue and psrl_back.
module python_syntax_run_lexer_top #(
   parameter int POS_BITS    = 24,  // 8 to 32
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,  // text_byte
   input  logic                           req_tlast,  // is_last
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [55:0]                    rsp_tdata,  // run_start, run_length, zero fill
   output logic                           rsp_tlast,  // final_res
   output logic [1:0]                     rsp_tuser,  // run_kind
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [psrl_pkg::START_BITS-1:0] csr_data   // start_offset
);
   import psrl_pkg::*;

   localparam int ENTRY_BITS = entry_bits(POS_BITS);

   logic                  q_full;
   logic                  q_push;
   logic [ENTRY_BITS-1:0] q_data;
   logic                  q_pop;
   logic                  q_head_valid;
   logic [ENTRY_BITS-1:0] q_head_data;

   // byte classification and run construction
   psrl_front #(
      .POS_BITS (POS_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_data     (q_data)
   );

   // run queue
   psrl_queue #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_data),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_data  (q_head_data)
   );

   // run output
   psrl_back #(
      .POS_BITS (POS_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_head_valid),
      .head_data  (q_head_data),
      .pop        (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ----- hdl/psrl_checker.sv -----
`timescale 1ns / 1ps
// psrl_checker: port-level checks of the run lexer top level
// bound to python_syntax_run_lexer_top; no package dependencies
module psrl_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic [1:0]  rsp_tuser
);

   // a stalled run holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled run changed");

   // no run of zero length ever leaves
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[48:24] != 25'd0)
      else $error("run of zero length");

   // after reset the output is empty and the queue has room
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("output or queue not empty after reset");

endmodule

bind python_syntax_run_lexer_top psrl_checker u_checker (.*);
